/* rtl/ktgw_pkg.sv */
// ----------------------------------------------------------------------------
// ktgw_pkg
// Shared types, grid geometry, code points and the half-width kana map for
// the kana text grid writer.
// ----------------------------------------------------------------------------
package ktgw_pkg;

    // Grid geometry and derived widths
    localparam int GRID_ROWS = 6;
    localparam int GRID_COLS = 16;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS + 1);
    localparam int NCOL_W    = $clog2(GRID_COLS);
    localparam int REC_MAX   = 5;
    localparam int CNT_W     = $clog2(REC_MAX + 1);

    // Code points
    localparam logic [15:0] CP_NUL        = 16'h0000;
    localparam logic [15:0] CP_SPACE      = 16'h0020;
    localparam logic [15:0] CP_STAR       = 16'h002A;
    localparam logic [15:0] CP_ASCII_LO   = 16'h0021;
    localparam logic [15:0] CP_ASCII_HI   = 16'h007E;
    localparam logic [15:0] CP_FW_OFFSET  = 16'hFEE0;
    localparam logic [15:0] CP_OPEN       = 16'h300C;
    localparam logic [15:0] CP_CLOSE      = 16'h300D;
    localparam logic [15:0] CP_DAKUTEN    = 16'h309B;
    localparam logic [15:0] CP_HANDAKUTEN = 16'h309C;
    localparam logic [15:0] CP_KANA_U     = 16'h30A6;
    localparam logic [15:0] CP_KANA_VU    = 16'h30F4;

    // Input byte codes
    localparam logic [7:0] CH_OPEN       = 8'h05;
    localparam logic [7:0] CH_CLOSE      = 8'h06;
    localparam logic [7:0] CH_KANA_FIRST = 8'hA1;
    localparam logic [7:0] CH_KANA_LAST  = 8'hDF;
    localparam logic [7:0] CH_HIGH       = 8'h80;

    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_SCROLL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  row;
        logic [4:0]  col;
        logic [15:0] glyph;
        logic        flag;
    } t_rec;

    typedef t_rec [REC_MAX-1:0] t_rec_list;

    // Half-width kana 0xA1..0xDF to full-width katakana
    localparam logic [15:0] KANA_TABLE [63] = '{
        16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2,
        16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9,
        16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC,
        16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3,
        16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
        16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8,
        16'h30CA, 16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE,
        16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB,
        16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2,
        16'h30E4, 16'h30E6, 16'h30E8,
        16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED,
        16'h30EF, 16'h30F3, 16'h309B, 16'h309C
    };

    // Map an input byte to its code point
    function automatic logic [15:0] map_char(logic [7:0] ch);
        logic [7:0]  off;
        logic [15:0] cp;
        off = ch - CH_KANA_FIRST;
        if (ch == CH_OPEN) begin
            cp = CP_OPEN;
        end else if (ch == CH_CLOSE) begin
            cp = CP_CLOSE;
        end else if (ch >= CH_KANA_FIRST && ch <= CH_KANA_LAST) begin
            cp = KANA_TABLE[off[5:0]];
        end else if (ch < CH_HIGH) begin
            cp = {8'h00, ch};
        end else begin
            cp = CP_STAR;
        end
        return cp;
    endfunction

endpackage

/* rtl/ktgw_step.sv */
// ----------------------------------------------------------------------------
// ktgw_step
// Grid state (cursor and newest cell) and the single-pass record builder.
// Produces the full record list of one character and commits the new state
// when the list is handed to the output buffer.
// ----------------------------------------------------------------------------
module ktgw_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [7:0]          i_char,
    output ktgw_pkg::t_rec_list o_recs,
    output logic [ktgw_pkg::CNT_W-1:0] o_count
);
    import ktgw_pkg::*;

    // Only the newest cell is ever read back, so its code point is kept alone
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic              r_new_valid, n_new_valid;
    logic [ROW_W-1:0]  r_new_row, n_new_row;
    logic [NCOL_W-1:0] r_new_col, n_new_col;
    logic [15:0]       r_new_cp, n_new_cp;

    logic [15:0]       cp;
    logic [15:0]       merged;
    logic              full;
    logic              bottom;
    logic [COL_W-1:0]  inc_col;
    logic [CNT_W-1:0]  n;
    t_rec_list         recs;

    function automatic logic takes_dakuten(logic [15:0] c);
        logic hit;
        case (c) inside
            16'h30A6, 16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3,
            16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
            16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8,
            16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic takes_handakuten(logic [15:0] c);
        logic hit;
        case (c) inside
            16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Zero means the mark does not combine with prev
    function automatic logic [15:0] merge_mark(logic [15:0] prev, logic [15:0] mark);
        logic [15:0] m;
        m = CP_NUL;
        if (mark == CP_DAKUTEN && takes_dakuten(prev)) begin
            m = (prev == CP_KANA_U) ? CP_KANA_VU : prev + 16'd1;
        end else if (mark == CP_HANDAKUTEN && takes_handakuten(prev)) begin
            m = prev + 16'd2;
        end
        return m;
    endfunction

    function automatic logic [15:0] to_glyph(logic [15:0] c);
        logic [15:0] g;
        if (c == CP_SPACE || c == CP_NUL) begin
            g = 16'h0000;
        end else if (c >= CP_ASCII_LO && c <= CP_ASCII_HI) begin
            g = c + CP_FW_OFFSET;
        end else begin
            g = c;
        end
        return g;
    endfunction

    function automatic t_rec mk_rec(t_kind k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                    logic [15:0] g, logic f);
        t_rec            rec;
        logic [ROW_W+2:0] rx;
        logic [COL_W+4:0] cx;
        rx        = {3'b000, r};
        cx        = {5'b00000, c};
        rec.kind  = k;
        rec.row   = rx[2:0];
        rec.col   = cx[4:0];
        rec.glyph = g;
        rec.flag  = f;
        return rec;
    endfunction

    // Build the record list and the next state
    always_comb begin
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_new_valid = r_new_valid;
        n_new_row   = r_new_row;
        n_new_col   = r_new_col;
        n_new_cp    = r_new_cp;
        recs        = '0;
        n           = '0;
        inc_col     = '0;
        cp          = map_char(i_char);
        merged      = merge_mark(r_new_cp, cp);
        full        = (r_cur_col == COL_W'(GRID_COLS));
        bottom      = (r_cur_row == ROW_W'(GRID_ROWS - 1));

        if (r_new_valid && merged != CP_NUL) begin
            // merge the mark into the newest cell
            n_new_cp = merged;
            recs[n]  = mk_rec(KIND_CELL, r_new_row, COL_W'(r_new_col), to_glyph(merged), 1'b1);
            n        = n + CNT_W'(1);
        end else begin
            // a space ends the highlight
            if (cp == CP_SPACE && r_new_valid) begin
                recs[n]     = mk_rec(KIND_CELL, r_new_row, COL_W'(r_new_col),
                                     to_glyph(r_new_cp), 1'b0);
                n           = n + CNT_W'(1);
                n_new_valid = 1'b0;
            end
            // wrap a full line, scrolling on the bottom row
            if (full) begin
                recs[n]   = mk_rec(KIND_CURSOR, r_cur_row, r_cur_col, 16'h0000, 1'b0);
                n         = n + CNT_W'(1);
                n_cur_col = '0;
                if (!bottom) begin
                    n_cur_row = r_cur_row + ROW_W'(1);
                end else begin
                    if (n_new_valid && r_new_row != '0) begin
                        n_new_row = r_new_row - ROW_W'(1);
                    end else begin
                        n_new_valid = 1'b0;
                    end
                    recs[n] = mk_rec(KIND_SCROLL, '0, '0, 16'h0000, 1'b0);
                    n       = n + CNT_W'(1);
                end
            end
            if (cp != CP_SPACE) begin
                // drop the old highlight, draw the new cell
                if (n_new_valid) begin
                    recs[n] = mk_rec(KIND_CELL, n_new_row, COL_W'(r_new_col),
                                     to_glyph(r_new_cp), 1'b0);
                    n       = n + CNT_W'(1);
                end
                recs[n]     = mk_rec(KIND_CELL, n_cur_row, n_cur_col, to_glyph(cp), 1'b1);
                n           = n + CNT_W'(1);
                n_new_valid = 1'b1;
                n_new_row   = n_cur_row;
                n_new_col   = n_cur_col[NCOL_W-1:0];
                n_new_cp    = cp;
                inc_col     = n_cur_col + COL_W'(1);
                n_cur_col   = inc_col;
                if (inc_col < COL_W'(GRID_COLS)) begin
                    recs[n] = mk_rec(KIND_CURSOR, n_cur_row, inc_col, 16'h0000, 1'b1);
                    n       = n + CNT_W'(1);
                end
            end else if (!full) begin
                // advance the cursor over a blank
                recs[n]   = mk_rec(KIND_CURSOR, r_cur_row, r_cur_col, 16'h0000, 1'b0);
                n         = n + CNT_W'(1);
                inc_col   = r_cur_col + COL_W'(1);
                n_cur_col = inc_col;
                if (inc_col < COL_W'(GRID_COLS)) begin
                    recs[n] = mk_rec(KIND_CURSOR, r_cur_row, inc_col, 16'h0000, 1'b1);
                    n       = n + CNT_W'(1);
                end
            end
        end
    end

    assign o_recs  = recs;
    assign o_count = n;

    // Commit state when the record list moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_new_valid <= 1'b0;
            r_new_row   <= '0;
            r_new_col   <= '0;
            r_new_cp    <= CP_SPACE;
        end else if (i_adv) begin
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_new_valid <= n_new_valid;
            r_new_row   <= n_new_row;
            r_new_col   <= n_new_col;
            r_new_cp    <= n_new_cp;
        end
    end

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col <= COL_W'(GRID_COLS))
        else $error("cursor column beyond line end");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row <= ROW_W'(GRID_ROWS - 1))
        else $error("cursor row beyond grid");

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |-> (o_count != '0 && o_count <= CNT_W'(REC_MAX)))
        else $error("item produced no records or too many");
`endif

endmodule

/* rtl/ktgw_out.sv */
// ----------------------------------------------------------------------------
// ktgw_out
// Result buffer: holds the record list of one character and hands the
// records out one per cycle while i_stall is low, marking the final one.
// ----------------------------------------------------------------------------
module ktgw_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  ktgw_pkg::t_rec_list        i_recs,
    input  logic [ktgw_pkg::CNT_W-1:0] i_count,
    output logic                       o_load_ready,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ktgw_pkg::t_rec             o_rec,
    output logic                       o_last
);
    import ktgw_pkg::*;

    logic             r_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    t_rec_list        r_recs;
    logic             take;
    logic             last;

    assign take         = r_valid && !i_stall;
    assign last         = (r_idx == r_count - CNT_W'(1));
    assign o_load_ready = !r_valid || (take && last);
    assign o_valid      = r_valid;
    assign o_rec        = r_recs[r_idx];
    assign o_last       = last;

    // Advance through the list, reload after the last record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_count <= i_count;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // Hold the record payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_recs <= i_recs;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < r_count)
        else $error("record index past list end");

    a_step_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !last) |=> (r_valid && r_idx == $past(r_idx) + CNT_W'(1)))
        else $error("record list ended early");
`endif

endmodule

/* rtl/kana_text_grid_writer.sv */
// ----------------------------------------------------------------------------
// kana_text_grid_writer
// Character byte in, grid draw/cursor/scroll records out.
// ----------------------------------------------------------------------------
// Each character byte produces one to five records, delivered one per cycle
// on the output port while i_stall is low; the output port is the only limit.
// The byte is first registered at the input, then its record list is
// registered in the output buffer, and the next byte is taken while the
// previous one's records are still being delivered. No clearing pass is
// needed after reset.
module kana_text_grid_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_row,
    output logic [4:0]  o_col,
    output logic [15:0] o_glyph,
    output logic        o_flag,
    output logic        o_last
);
    import ktgw_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             accept;
    logic             step_adv;
    logic             load_ready;
    t_rec_list        recs;
    logic [CNT_W-1:0] count;
    t_rec             rec;

    assign step_adv = r_in_valid && load_ready;
    assign o_stall  = r_in_valid && !load_ready;
    assign accept   = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_code;
        end
    end

    ktgw_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (step_adv),
        .i_char  (r_in_char),
        .o_recs  (recs),
        .o_count (count)
    );

    ktgw_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (step_adv),
        .i_recs       (recs),
        .i_count      (count),
        .o_load_ready (load_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rec        (rec),
        .o_last       (o_last)
    );

    assign o_kind  = rec.kind;
    assign o_row   = rec.row;
    assign o_col   = rec.col;
    assign o_glyph = rec.glyph;
    assign o_flag  = rec.flag;

endmodule

/* tb/tb_kana_text_grid_writer.sv */
// ----------------------------------------------------------------------------
// tb_kana_text_grid_writer
// Self-checking bench for the kana text grid writer.
// ----------------------------------------------------------------------------
// Each character byte sent to the block is run through a local model of the
// 6x16 text grid. The model covers the cursor, the highlighted newest cell,
// the dakuten and handakuten merges, line wraps and scrolling. It queues the
// draw, cursor and scroll records that the byte must produce. A monitor
// compares every record the block delivers, field by field, with the oldest
// queued one. Both ports idle at random. One phase holds the output off
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_kana_text_grid_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import ktgw_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 40;

    // Input bytes used by name in the stimulus
    localparam logic [7:0] BYTE_NUL        = 8'h00;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_ALL_ONES   = 8'hFF;
    localparam logic [7:0] BYTE_KANA_A     = 8'hB1;
    localparam logic [7:0] BYTE_KANA_U     = 8'hB3;
    localparam logic [7:0] BYTE_KANA_KA    = 8'hB6;
    localparam logic [7:0] BYTE_KANA_TO    = 8'hC4;
    localparam logic [7:0] BYTE_KANA_HA    = 8'hCA;
    localparam logic [7:0] BYTE_KANA_HO    = 8'hCE;
    localparam logic [7:0] BYTE_DAKUTEN    = 8'hDE;
    localparam logic [7:0] BYTE_HANDAKUTEN = 8'hDF;
    localparam logic [7:0] BYTE_PRINT_LO   = 8'h21;
    localparam logic [7:0] BYTE_PRINT_HI   = 8'h7E;

    // Kana that take a handakuten
    localparam logic [15:0] KANA_HA = 16'h30CF;
    localparam logic [15:0] KANA_HI = 16'h30D2;
    localparam logic [15:0] KANA_FU = 16'h30D5;
    localparam logic [15:0] KANA_HE = 16'h30D8;
    localparam logic [15:0] KANA_HO = 16'h30DB;

    // Half-width kana 0xA1..0xDF as full-width katakana
    localparam logic [15:0] HALFWIDTH_KANA [63] = '{
        16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2,
        16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9,
        16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC,
        16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3,
        16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
        16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8,
        16'h30CA, 16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE,
        16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB,
        16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2,
        16'h30E4, 16'h30E6, 16'h30E8,
        16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED,
        16'h30EF, 16'h30F3, 16'h309B, 16'h309C
    };

    // Kana that take a dakuten
    localparam logic [15:0] VOICED_BASES [21] = '{
        16'h30A6,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3,
        16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD,
        16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8,
        16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB
    };

    typedef struct {
        t_kind       kind;
        logic [2:0]  row;
        logic [4:0]  col;
        logic [15:0] glyph;
        logic        flag;
        logic        last;
    } t_grid_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_code;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [2:0]  o_row;
    logic [4:0]  o_col;
    logic [15:0] o_glyph;
    logic        o_flag;
    logic        o_last;

    // Grid model
    logic [15:0] grid_cp [GRID_ROWS][GRID_COLS];
    int          cur_row;
    int          cur_col;
    bit          hl_valid;
    int          hl_row;
    int          hl_col;

    t_grid_rec   char_recs[$];
    t_grid_rec   grid_records_due[$];

    int          err_count;
    int          tx_idle_pct;
    int          rx_busy_pct;
    bit          hold_req;

    kana_text_grid_writer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_row       (o_row),
        .o_col       (o_col),
        .o_glyph     (o_glyph),
        .o_flag      (o_flag),
        .o_last      (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------------

    function automatic void clear_grid_model();
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                grid_cp[r][c] = CP_SPACE;
            end
        end
        cur_row  = 0;
        cur_col  = 0;
        hl_valid = 1'b0;
        hl_row   = 0;
        hl_col   = 0;
    endfunction

    function automatic logic [15:0] code_point_of(logic [7:0] b);
        if (b == CH_OPEN) begin
            return CP_OPEN;
        end else if (b == CH_CLOSE) begin
            return CP_CLOSE;
        end else if (b >= CH_KANA_FIRST && b <= CH_KANA_LAST) begin
            return HALFWIDTH_KANA[b - CH_KANA_FIRST];
        end else if (b < CH_HIGH) begin
            return {8'h00, b};
        end
        return CP_STAR;
    endfunction

    // Blank for space and NUL, full-width form for printable ASCII
    function automatic logic [15:0] glyph_of(logic [15:0] cp);
        if (cp == CP_SPACE || cp == CP_NUL) begin
            return 16'h0000;
        end else if (cp >= CP_ASCII_LO && cp <= CP_ASCII_HI) begin
            return cp + CP_FW_OFFSET;
        end
        return cp;
    endfunction

    function automatic bit takes_dakuten(logic [15:0] cp);
        foreach (VOICED_BASES[i]) begin
            if (VOICED_BASES[i] == cp) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit takes_handakuten(logic [15:0] cp);
        return cp == KANA_HA || cp == KANA_HI || cp == KANA_FU
            || cp == KANA_HE || cp == KANA_HO;
    endfunction

    function automatic void add_rec(t_kind kind, int row, int col,
                                    logic [15:0] glyph, logic flag);
        t_grid_rec rec;
        rec.kind  = kind;
        rec.row   = row[2:0];
        rec.col   = col[4:0];
        rec.glyph = glyph;
        rec.flag  = flag;
        rec.last  = 1'b0;
        char_recs.push_back(rec);
    endfunction

    function automatic void add_cell(int row, int col, logic flag);
        add_rec(KIND_CELL, row, col, glyph_of(grid_cp[row][col]), flag);
    endfunction

    // Erase the cursor at the line end, then go down a row or scroll
    function automatic void wrap_line();
        add_rec(KIND_CURSOR, cur_row, cur_col, 16'h0000, 1'b0);
        cur_col = 0;
        if (cur_row < GRID_ROWS - 1) begin
            cur_row++;
        end else begin
            for (int r = 0; r < GRID_ROWS - 1; r++) begin
                grid_cp[r] = grid_cp[r + 1];
            end
            for (int c = 0; c < GRID_COLS; c++) begin
                grid_cp[GRID_ROWS - 1][c] = CP_SPACE;
            end
            if (hl_valid && hl_row > 0) begin
                hl_row--;
            end else begin
                hl_valid = 1'b0;
            end
            add_rec(KIND_SCROLL, 0, 0, 16'h0000, 1'b0);
        end
    endfunction

    function automatic void write_code(logic [15:0] cp);
        logic [15:0] prev;
        logic [15:0] merged;
        // Merge a voicing mark into the newest cell where the kana allows it
        if (hl_valid && (cp == CP_DAKUTEN || cp == CP_HANDAKUTEN)) begin
            prev   = grid_cp[hl_row][hl_col];
            merged = 16'h0000;
            if (cp == CP_DAKUTEN && takes_dakuten(prev)) begin
                merged = (prev == CP_KANA_U) ? CP_KANA_VU : prev + 16'd1;
            end else if (cp == CP_HANDAKUTEN && takes_handakuten(prev)) begin
                merged = prev + 16'd2;
            end
            if (merged != 16'h0000) begin
                grid_cp[hl_row][hl_col] = merged;
                add_cell(hl_row, hl_col, 1'b1);
                return;
            end
        end
        if (cur_col >= GRID_COLS) begin
            wrap_line();
        end
        if (hl_valid) begin
            add_cell(hl_row, hl_col, 1'b0);
        end
        grid_cp[cur_row][cur_col] = cp;
        add_cell(cur_row, cur_col, 1'b1);
        hl_valid = 1'b1;
        hl_row   = cur_row;
        hl_col   = cur_col;
        cur_col++;
        if (cur_col < GRID_COLS) begin
            add_rec(KIND_CURSOR, cur_row, cur_col, 16'h0000, 1'b1);
        end
    endfunction

    // Queue the records that one character byte produces
    function automatic void predict_char_records(logic [7:0] b);
        logic [15:0] cp;
        t_grid_rec   rec;
        char_recs.delete();
        cp = code_point_of(b);
        if (cp != CP_SPACE) begin
            write_code(cp);
        end else begin
            if (hl_valid) begin
                add_cell(hl_row, hl_col, 1'b0);
                hl_valid = 1'b0;
            end
            if (cur_col >= GRID_COLS) begin
                wrap_line();
            end else begin
                add_rec(KIND_CURSOR, cur_row, cur_col, 16'h0000, 1'b0);
                grid_cp[cur_row][cur_col] = CP_SPACE;
                cur_col++;
                if (cur_col < GRID_COLS) begin
                    add_rec(KIND_CURSOR, cur_row, cur_col, 16'h0000, 1'b1);
                end
            end
        end
        rec      = char_recs.pop_back();
        rec.last = 1'b1;
        char_recs.push_back(rec);
        foreach (char_recs[i]) begin
            grid_records_due.push_back(char_recs[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Pacing and stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int idle_len(int pct);
        if (pct == 0 || $urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(99) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int sel;
        int b;
        sel = $urandom_range(99);
        if (sel < 30) begin
            b = $urandom_range(CH_KANA_LAST, CH_KANA_FIRST);
        end else if (sel < 45) begin
            b = $urandom_range(1) ? BYTE_DAKUTEN : BYTE_HANDAKUTEN;
        end else if (sel < 60) begin
            b = BYTE_SPACE;
        end else if (sel < 85) begin
            b = $urandom_range(BYTE_PRINT_HI, BYTE_PRINT_LO);
        end else begin
            b = $urandom_range(255);
        end
        return b[7:0];
    endfunction

    function automatic logic [7:0] pick_filler_byte();
        int b;
        if ($urandom_range(1)) begin
            b = $urandom_range(CH_KANA_LAST, CH_KANA_FIRST);
        end else begin
            b = $urandom_range(BYTE_PRINT_HI, BYTE_PRINT_LO);
        end
        return b[7:0];
    endfunction

    // A kana that takes a dakuten, or a handakuten when semi is set
    function automatic logic [7:0] pick_voiceable_byte(bit semi);
        int b;
        if (semi) begin
            b = $urandom_range(BYTE_KANA_HO, BYTE_KANA_HA);
        end else begin
            case ($urandom_range(2))
                0: b = BYTE_KANA_U;
                1: b = $urandom_range(BYTE_KANA_TO, BYTE_KANA_KA);
                default: b = $urandom_range(BYTE_KANA_HO, BYTE_KANA_HA);
            endcase
        end
        return b[7:0];
    endfunction

    // Offer one item, hold it until taken, then idle for a while
    task automatic send_char(input logic [7:0] code);
        int gap;
        i_valid     <= 1'b1;
        i_char_code <= code;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_char_records(code);
        gap = idle_len(tx_idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Byte classes and their extremes, brackets, controls, spaces
    task automatic test_byte_classes();
        logic [7:0] codes[$];
        codes = '{BYTE_NUL, BYTE_ALL_ONES, 8'h7F, 8'h41, CH_OPEN, CH_CLOSE,
                  CH_HIGH, 8'hA0, CH_KANA_FIRST, BYTE_HANDAKUTEN, 8'hE0,
                  8'h01, BYTE_SPACE, BYTE_SPACE};
        foreach (codes[i]) begin
            send_char(codes[i]);
        end
    endtask

    // Dakuten and handakuten merges, refused merges and lone marks
    task automatic test_voicing_marks();
        logic [7:0] codes[$];
        codes = '{BYTE_KANA_U, BYTE_DAKUTEN, BYTE_KANA_KA, BYTE_DAKUTEN,
                  BYTE_DAKUTEN, BYTE_KANA_HA, BYTE_HANDAKUTEN,
                  BYTE_KANA_HO, BYTE_DAKUTEN, BYTE_KANA_A, BYTE_HANDAKUTEN,
                  BYTE_SPACE, BYTE_DAKUTEN};
        foreach (codes[i]) begin
            send_char(codes[i]);
        end
    endtask

    // Fill lines to the end and vary what arrives at the full line
    task automatic test_line_wrap(input int lines);
        int end_kind;
        repeat (lines) begin
            end_kind = $urandom_range(3);
            while (cur_col < GRID_COLS) begin
                if (cur_col == GRID_COLS - 1 && end_kind == 1) begin
                    send_char(pick_voiceable_byte(1'b0));
                end else begin
                    send_char(pick_filler_byte());
                end
            end
            case (end_kind)
                0: send_char(BYTE_SPACE);
                1: send_char(BYTE_DAKUTEN);
                2: send_char($urandom_range(1) ? BYTE_DAKUTEN : BYTE_HANDAKUTEN);
                default: send_char(pick_filler_byte());
            endcase
        end
    endtask

    // Hold the output off while items keep coming, so the input stalls
    task automatic test_output_hold(input int items);
        int saved_idle;
        saved_idle  = tx_idle_pct;
        tx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (items) begin
            send_char(pick_text_byte());
        end
        i_valid <= 1'b0;
        while (hold_req) begin
            @(posedge i_clk);
        end
        tx_idle_pct = saved_idle;
    endtask

    // Random text, kana with marks that merge mixed with other bytes and noise
    task automatic test_random_text(input int items, input int tx_pct,
                                    input int rx_pct);
        int  sent;
        bit  semi;
        tx_idle_pct = tx_pct;
        rx_busy_pct = rx_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(3) == 0) begin
                semi = $urandom_range(1);
                send_char(pick_voiceable_byte(semi));
                send_char(semi ? BYTE_HANDAKUTEN : BYTE_DAKUTEN);
                sent += 2;
            end else begin
                send_char(pick_text_byte());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: random stalls, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin : rx_pacing
        int len;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                for (len = 0; len < HOLD_CYCLES; len++) begin
                    @(posedge i_clk);
                end
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else begin
                len = idle_len(rx_busy_pct);
                if (len > 0) begin
                    i_stall <= 1'b1;
                    repeat (len) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Check every delivered record against the oldest one due
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_grid_rec due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (grid_records_due.size() == 0) begin
                report_mismatch($sformatf("unexpected record kind %0d row %0d col %0d",
                                          o_kind, o_row, o_col));
            end else begin
                due = grid_records_due.pop_front();
                check_field("kind", o_kind, due.kind);
                check_field("row", o_row, due.row);
                check_field("col", o_col, due.col);
                check_field("glyph", o_glyph, due.glyph);
                check_field("flag", o_flag, due.flag);
                check_field("last", o_last, due.last);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= BYTE_NUL;
        err_count   = 0;
        hold_req    = 1'b0;
        tx_idle_pct = 25;
        rx_busy_pct = 25;
        clear_grid_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_byte_classes();
        test_voicing_marks();
        test_line_wrap(7);
        test_output_hold(40);
        test_random_text(65, 30, 30);
        test_random_text(65, 0, 0);
        test_random_text(65, 60, 10);
        test_random_text(65, 10, 60);

        // Drain the remaining records, then watch for strays
        i_valid <= 1'b0;
        while (grid_records_due.size() != 0) begin
            @(posedge i_clk);
        end
        rx_busy_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && grid_records_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ktgw_pkg.sv
rtl/ktgw_step.sv
rtl/ktgw_out.sv
rtl/kana_text_grid_writer.sv
tb/tb_kana_text_grid_writer.sv
